// ===== src/bts_pkg.sv =====
// Shared constants, codes and stage types of the bilinear texture sampler.
// Depends on nothing; every other file of the block imports it.
package bts_pkg;

    // Texture geometry: the store holds MAX_DIM by MAX_DIM texels.
    localparam int DIM_BITS  = 8;
    localparam int SIZE_BITS = DIM_BITS + 1;
    localparam int ADDR_BITS = 2 * DIM_BITS;
    localparam logic [SIZE_BITS-1:0] MAX_DIM = SIZE_BITS'(1) << DIM_BITS;

    // Coordinates, texels and channels.
    localparam int COORD_BITS = 16;
    localparam int TEXEL_BITS = 32;
    localparam int CH_BITS    = 8;
    localparam int CHANNELS   = 4;

    // Scaled coordinate and fractional weights.
    localparam int Q_BITS      = COORD_BITS + SIZE_BITS;
    localparam int WEIGHT_BITS = 8;
    localparam int TOP_BITS    = CH_BITS + WEIGHT_BITS;
    localparam int SUM_BITS    = CH_BITS + 2 * WEIGHT_BITS;
    localparam logic [Q_BITS-1:0] HALF_TEXEL = Q_BITS'(1) << (COORD_BITS - 1);
    localparam logic [WEIGHT_BITS:0] WEIGHT_ONE = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;
    localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (2 * WEIGHT_BITS - 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TEX_HEIGHT = 2'd1;

    // Item kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [TEXEL_BITS-1:0]  texel_t;

    // Addresses and weights handed from the address stage to the store.
    typedef struct packed {
        logic    valid;
        logic    kind;
        addr_t   wr_addr;
        texel_t  wr_data;
        addr_t   addr00;
        addr_t   addr10;
        addr_t   addr01;
        addr_t   addr11;
        weight_t wx;
        weight_t wy;
    } addr_stage_t;

    // Four fetched texels handed from the store to the blend stages.
    typedef struct packed {
        logic    valid;
        texel_t  t00;
        texel_t  t10;
        texel_t  t01;
        texel_t  t11;
        weight_t wx;
        weight_t wy;
    } fetch_stage_t;

endpackage

// ===== src/bts_if.sv =====
// Handshake interfaces of the sampler: configuration, request and result channels.
// Depends on bts_pkg for field widths.
interface bts_cfg_if import bts_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [SIZE_BITS-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bts_req_if import bts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [DIM_BITS-1:0]   texel_col;
    logic [DIM_BITS-1:0]   texel_row;
    logic [TEXEL_BITS-1:0] texel_rgba;
    logic [COORD_BITS-1:0] coord_u;
    logic [COORD_BITS-1:0] coord_v;
    modport source (output valid, output kind, output texel_col, output texel_row,
                    output texel_rgba, output coord_u, output coord_v, input ready);
    modport sink   (input valid, input kind, input texel_col, input texel_row,
                    input texel_rgba, input coord_u, input coord_v, output ready);
endinterface

interface bts_res_if import bts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] alpha;
    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

// ===== src/bts_addr_gen.sv =====
// Address stages: scales coordinates, derives wrapped neighbours and weights.
// Depends on bts_pkg; two register stages.
module bts_addr_gen import bts_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic                  kind,
    input  logic [DIM_BITS-1:0]   texel_col,
    input  logic [DIM_BITS-1:0]   texel_row,
    input  logic [TEXEL_BITS-1:0] texel_rgba,
    input  logic [COORD_BITS-1:0] coord_u,
    input  logic [COORD_BITS-1:0] coord_v,
    input  logic [SIZE_BITS-1:0]  tex_width,
    input  logic [SIZE_BITS-1:0]  tex_height,
    output addr_stage_t           stage_out
);

    logic                 s1_valid_reg;
    logic                 s1_kind_reg;
    addr_t                s1_wr_addr_reg;
    texel_t               s1_wr_data_reg;
    logic [Q_BITS-1:0]    s1_qu_reg;
    logic [Q_BITS-1:0]    s1_qv_reg;
    logic [SIZE_BITS-1:0] s1_w_reg;
    logic [SIZE_BITS-1:0] s1_h_reg;

    logic [SIZE_BITS-1:0] w_eff;
    logic [SIZE_BITS-1:0] h_eff;
    logic [Q_BITS-1:0]    qu_next;
    logic [Q_BITS-1:0]    qv_next;
    logic [SIZE_BITS-1:0] cell_u;
    logic [SIZE_BITS-1:0] cell_v;
    logic [SIZE_BITS-1:0] x0_wide;
    logic [SIZE_BITS-1:0] x1_wide;
    logic [SIZE_BITS-1:0] y0_wide;
    logic [SIZE_BITS-1:0] y1_wide;
    logic [DIM_BITS-1:0]  x0;
    logic [DIM_BITS-1:0]  x1;
    logic [DIM_BITS-1:0]  y0;
    logic [DIM_BITS-1:0]  y1;
    addr_stage_t          stage_next;
    addr_stage_t          stage_reg;
    logic                 s2_valid_reg;

    // A zero size counts as one texel; a size beyond the store saturates.
    always_comb
    begin
        if (tex_width == '0)
            w_eff = SIZE_BITS'(1);
        else if (tex_width > MAX_DIM)
            w_eff = MAX_DIM;
        else
            w_eff = tex_width;
        if (tex_height == '0)
            h_eff = SIZE_BITS'(1);
        else if (tex_height > MAX_DIM)
            h_eff = MAX_DIM;
        else
            h_eff = tex_height;
    end

    // Scale by the size and add half a texel; the floor then sits one below.
    assign qu_next = Q_BITS'(coord_u) * Q_BITS'(w_eff) + HALF_TEXEL;
    assign qv_next = Q_BITS'(coord_v) * Q_BITS'(h_eff) + HALF_TEXEL;

    // First stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= in_valid;
    end

    // First stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg    <= kind;
            s1_wr_addr_reg <= {texel_row, texel_col};
            s1_wr_data_reg <= texel_rgba;
            s1_qu_reg      <= qu_next;
            s1_qv_reg      <= qv_next;
            s1_w_reg       <= w_eff;
            s1_h_reg       <= h_eff;
        end
    end

    // Neighbours with repeat wrap: minus one wraps to the last texel, size to zero.
    assign cell_u  = s1_qu_reg[Q_BITS-1:COORD_BITS];
    assign cell_v  = s1_qv_reg[Q_BITS-1:COORD_BITS];
    assign x0_wide = (cell_u == '0) ? (s1_w_reg - SIZE_BITS'(1)) : (cell_u - SIZE_BITS'(1));
    assign x1_wide = (cell_u >= s1_w_reg) ? '0 : cell_u;
    assign y0_wide = (cell_v == '0) ? (s1_h_reg - SIZE_BITS'(1)) : (cell_v - SIZE_BITS'(1));
    assign y1_wide = (cell_v >= s1_h_reg) ? '0 : cell_v;
    assign x0 = x0_wide[DIM_BITS-1:0];
    assign x1 = x1_wide[DIM_BITS-1:0];
    assign y0 = y0_wide[DIM_BITS-1:0];
    assign y1 = y1_wide[DIM_BITS-1:0];

    always_comb
    begin
        stage_next.valid   = s1_valid_reg;
        stage_next.kind    = s1_kind_reg;
        stage_next.wr_addr = s1_wr_addr_reg;
        stage_next.wr_data = s1_wr_data_reg;
        stage_next.addr00  = {y0, x0};
        stage_next.addr10  = {y0, x1};
        stage_next.addr01  = {y1, x0};
        stage_next.addr11  = {y1, x1};
        stage_next.wx      = s1_qu_reg[COORD_BITS-1 -: WEIGHT_BITS];
        stage_next.wy      = s1_qv_reg[COORD_BITS-1 -: WEIGHT_BITS];
    end

    // Second stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= stage_next.valid;
    end

    // Second stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            stage_reg <= stage_next;
    end

    // The payload leaves with the reset-controlled valid bit.
    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = s2_valid_reg;
    end

endmodule

// ===== src/bts_texel_store.sv =====
// Texel store: two identical copies, each with one write and two read ports.
// Depends on bts_pkg; the read data forms the third pipeline stage.
module bts_texel_store import bts_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  addr_stage_t  stage_in,
    output fetch_stage_t stage_out
);

    localparam int DEPTH = 1 << ADDR_BITS;

    texel_t       mem_top [0:DEPTH-1];
    texel_t       mem_bot [0:DEPTH-1];
    logic         valid_reg;
    texel_t       t00_reg;
    texel_t       t10_reg;
    texel_t       t01_reg;
    texel_t       t11_reg;
    weight_t      wx_reg;
    weight_t      wy_reg;
    logic         do_write;

    assign do_write = stage_in.valid && (stage_in.kind == KIND_WRITE);

    // Top row copy: written by every texel write, read at the upper two neighbours.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (do_write)
                mem_top[stage_in.wr_addr] <= stage_in.wr_data;
            t00_reg <= mem_top[stage_in.addr00];
            t10_reg <= mem_top[stage_in.addr10];
        end
    end

    // Bottom row copy: same contents, read at the lower two neighbours.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (do_write)
                mem_bot[stage_in.wr_addr] <= stage_in.wr_data;
            t01_reg <= mem_bot[stage_in.addr01];
            t11_reg <= mem_bot[stage_in.addr11];
        end
    end

    // Only sample items carry on; a write ends here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= stage_in.valid && (stage_in.kind == KIND_SAMPLE);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wx_reg <= stage_in.wx;
            wy_reg <= stage_in.wy;
        end
    end

    always_comb
    begin
        stage_out.valid = valid_reg;
        stage_out.t00   = t00_reg;
        stage_out.t10   = t10_reg;
        stage_out.t01   = t01_reg;
        stage_out.t11   = t11_reg;
        stage_out.wx    = wx_reg;
        stage_out.wy    = wy_reg;
    end

endmodule

// ===== src/bts_blend.sv =====
// Blend stages: horizontal then vertical weighting per channel, then rounding.
// Depends on bts_pkg; the last register stage is the result register.
module bts_blend import bts_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  fetch_stage_t       stage_in,
    output logic               out_valid,
    output logic [CH_BITS-1:0] red,
    output logic [CH_BITS-1:0] green,
    output logic [CH_BITS-1:0] blue,
    output logic [CH_BITS-1:0] alpha
);

    logic                  s4_valid_reg;
    logic [TOP_BITS-1:0]   top_reg [CHANNELS];
    logic [TOP_BITS-1:0]   bot_reg [CHANNELS];
    weight_t               s4_wy_reg;
    logic [TOP_BITS-1:0]   top_next [CHANNELS];
    logic [TOP_BITS-1:0]   bot_next [CHANNELS];
    logic [WEIGHT_BITS:0]  fx;
    logic [WEIGHT_BITS:0]  fy;
    logic [SUM_BITS-1:0]   sum [CHANNELS];
    logic [CH_BITS-1:0]    res_next [CHANNELS];
    logic                  valid_reg;
    logic [CH_BITS-1:0]    res_reg [CHANNELS];

    // Horizontal weighting of both rows, one lane per channel.
    assign fx = WEIGHT_ONE - {1'b0, stage_in.wx};
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            top_next[ch] = TOP_BITS'(stage_in.t00[ch*CH_BITS +: CH_BITS]) * TOP_BITS'(fx)
                         + TOP_BITS'(stage_in.t10[ch*CH_BITS +: CH_BITS])
                           * TOP_BITS'(stage_in.wx);
            bot_next[ch] = TOP_BITS'(stage_in.t01[ch*CH_BITS +: CH_BITS]) * TOP_BITS'(fx)
                         + TOP_BITS'(stage_in.t11[ch*CH_BITS +: CH_BITS])
                           * TOP_BITS'(stage_in.wx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (advance)
            s4_valid_reg <= stage_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            s4_wy_reg <= stage_in.wy;
        end
    end

    // Vertical weighting and rounding to eight bits.
    assign fy = WEIGHT_ONE - {1'b0, s4_wy_reg};
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            sum[ch] = SUM_BITS'(top_reg[ch]) * SUM_BITS'(fy)
                    + SUM_BITS'(bot_reg[ch]) * SUM_BITS'(s4_wy_reg) + ROUND_HALF;
            res_next[ch] = sum[ch][2*WEIGHT_BITS +: CH_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign red       = res_reg[0];
    assign green     = res_reg[1];
    assign blue      = res_reg[2];
    assign alpha     = res_reg[3];

endmodule

// ===== src/bilinear_texture_sampler.sv =====
// Bilinear texture sampler with repeat wrap: top level, configuration and stall control.
// A sample passes the two address registers, the store read register, the blend register and the result register.
// Throughput: one item per cycle; the pipeline holds as a whole while a result waits.
// Write items pass through the pipeline and update the store in the third stage.
// Reset clears valid bits and sets both sizes to 256; texel contents stay undefined.
// Depends on bts_pkg, bts_if, bts_addr_gen, bts_texel_store and bts_blend.
module bilinear_texture_sampler import bts_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    bts_cfg_if.sink    cfg,
    bts_req_if.sink    request,
    bts_res_if.source  result
);

    logic [SIZE_BITS-1:0] tex_width_reg;
    logic [SIZE_BITS-1:0] tex_height_reg;
    logic                 advance;
    logic                 out_valid;
    addr_stage_t          addr_stage;
    fetch_stage_t         fetch_stage;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= MAX_DIM;
            tex_height_reg <= MAX_DIM;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TEX_WIDTH:  tex_width_reg  <= cfg.data;
                REG_TEX_HEIGHT: tex_height_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // The whole pipeline moves when the result register is empty or being taken.
    assign advance       = !out_valid || result.ready;
    assign request.ready = advance;

    bts_addr_gen u_addr_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (request.valid),
        .kind       (request.kind),
        .texel_col  (request.texel_col),
        .texel_row  (request.texel_row),
        .texel_rgba (request.texel_rgba),
        .coord_u    (request.coord_u),
        .coord_v    (request.coord_v),
        .tex_width  (tex_width_reg),
        .tex_height (tex_height_reg),
        .stage_out  (addr_stage)
    );

    bts_texel_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .stage_in  (addr_stage),
        .stage_out (fetch_stage)
    );

    bts_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .stage_in  (fetch_stage),
        .out_valid (out_valid),
        .red       (result.red),
        .green     (result.green),
        .blue      (result.blue),
        .alpha     (result.alpha)
    );

    assign result.valid = out_valid;

endmodule

// ===== src/bts_checker.sv =====
// Port-level checker for the bilinear texture sampler, bound to the top level.
// Depends on bts_pkg for field widths.
module bts_checker import bts_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               req_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [CH_BITS-1:0] res_red,
    input logic [CH_BITS-1:0] res_alpha
);

    // A result that waits stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before transfer");

    // A waiting result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_red) && $stable(res_alpha))
        else $error("result changed while stalled");

    // While a result waits, no new request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !req_ready)
        else $error("request taken while the pipeline is held");

    // With no result pending, requests are always taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request refused with an empty result register");

    // Configuration writes never stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_red   (result.red),
    .res_alpha (result.alpha)
);

// ===== test/bilinear_texture_sampler_test.sv =====
// Testbench of the bilinear texture sampler: directed table, then random phases at many sizes.
// Checks every filtered sample against a local bilinear predictor with repeat wrap or a typed-in colour.
// Depends on bts_pkg, bts_if and the bilinear_texture_sampler top level.
module bilinear_texture_sampler_test;
    import bts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH  = 65536;
    localparam int WATCHDOG_MAX = 20000;
    localparam int DRAIN_CYCLES = 10;

    // One request item, with an optional typed-in expected colour.
    typedef struct {
        logic        kind;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] rgba;
        logic [15:0] u;
        logic [15:0] v;
        bit          typed;
        logic [31:0] typed_rgba;
    } tex_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bts_cfg_if cfg_ch ();
    bts_req_if req_ch ();
    bts_res_if res_ch ();

    bilinear_texture_sampler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .request (req_ch),
        .result  (res_ch)
    );

    always #5 clk = ~clk;

    // Stimulus queue, predicted colours and the predictor's own texture state.
    tex_item_t   pending_items[$];
    tex_item_t   in_flight;
    logic [31:0] expected_colours[$];
    logic [31:0] model_texels [STORE_DEPTH];
    bit          planned_texels [STORE_DEPTH];
    logic [8:0]  model_width = 9'd256;
    logic [8:0]  model_height = 9'd256;
    logic [8:0]  plan_width = 9'd256;
    logic [8:0]  plan_height = 9'd256;
    int          fail_count = 0;
    int          write_count = 0;
    int          sample_count = 0;
    int          colour_count = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          cycle_count = 0;
    int          quiet_cycles = 0;

    function automatic int unsigned size_in_use(logic [8:0] reg_value);
        if (reg_value == 9'd0)
            return 1;
        if (reg_value > 9'd256)
            return 256;
        return reg_value;
    endfunction

    // Neighbour indices and weight along one axis, with repeat wrap.
    function automatic void wrap_axis(input logic [15:0] coord, input int unsigned size,
                                      output int unsigned lo, output int unsigned hi,
                                      output int unsigned weight);
        longint unsigned q;
        int unsigned     texel_pos;
        q = longint'(coord) * size + 32768;
        texel_pos = int'(q >> 16);
        lo = (texel_pos == 0) ? size - 1 : texel_pos - 1;
        hi = (texel_pos >= size) ? 0 : texel_pos;
        weight = int'(q & 16'hFFFF) >> (16 - WEIGHT_BITS);
    endfunction

    // Bilinear blend of the four neighbours, each channel rounded to eight bits.
    function automatic logic [31:0] filter_colour(logic [15:0] u, logic [15:0] v);
        int unsigned     x0, x1, wx, y0, y1, wy;
        logic [31:0]     t00, t10, t01, t11, colour;
        longint unsigned top, bot, sum, full;
        full = 1 << WEIGHT_BITS;
        wrap_axis(u, size_in_use(model_width), x0, x1, wx);
        wrap_axis(v, size_in_use(model_height), y0, y1, wy);
        t00 = model_texels[y0 * 256 + x0];
        t10 = model_texels[y0 * 256 + x1];
        t01 = model_texels[y1 * 256 + x0];
        t11 = model_texels[y1 * 256 + x1];
        for (int ch = 0; ch < 4; ch++)
        begin
            top = t00[ch*8 +: 8] * (full - wx) + t10[ch*8 +: 8] * wx;
            bot = t01[ch*8 +: 8] * (full - wx) + t11[ch*8 +: 8] * wx;
            sum = top * (full - wy) + bot * wy;
            colour[ch*8 +: 8] = 8'((sum + (1 << (2 * WEIGHT_BITS - 1))) >> (2 * WEIGHT_BITS));
        end
        return colour;
    endfunction

    task automatic queue_write(logic [7:0] col, logic [7:0] row, logic [31:0] rgba);
        tex_item_t it;
        it = '{KIND_WRITE, col, row, rgba, 16'($urandom), 16'($urandom), 1'b0, 32'd0};
        planned_texels[{row, col}] = 1'b1;
        pending_items.push_back(it);
        write_count++;
    endtask

    // A sample is preceded by writes to any neighbour that holds nothing yet.
    task automatic queue_sample(logic [15:0] u, logic [15:0] v, bit typed,
                                logic [31:0] typed_rgba);
        int unsigned x[2], y[2], wx, wy;
        tex_item_t   it;
        wrap_axis(u, size_in_use(plan_width), x[0], x[1], wx);
        wrap_axis(v, size_in_use(plan_height), y[0], y[1], wy);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                if (!planned_texels[y[j] * 256 + x[i]])
                    queue_write(8'(x[i]), 8'(y[j]), $urandom);
        it = '{KIND_SAMPLE, 8'($urandom), 8'($urandom), $urandom, u, v, typed, typed_rgba};
        pending_items.push_back(it);
        sample_count++;
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index, logic [8:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (index == REG_TEX_WIDTH)
        begin
            model_width = value;
            plan_width  = value;
        end
        else
        begin
            model_height = value;
            plan_height  = value;
        end
        @(posedge clk);
    endtask

    // Idle means nothing queued, nothing presented and no colour outstanding.
    task automatic wait_until_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || req_ch.valid || expected_colours.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int items);
        int          target;
        int unsigned w, h, pick;
        logic [15:0] u, v;
        target = write_count + sample_count + items;
        w = size_in_use(plan_width);
        h = size_in_use(plan_height);
        while (write_count + sample_count < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                queue_write(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
                            $urandom);
            else if (pick == 3)
                queue_write(8'($urandom), 8'($urandom), $urandom);
            else
            begin
                u = ($urandom_range(0, 7) == 0) ? {16{1'($urandom)}} : 16'($urandom);
                v = ($urandom_range(0, 7) == 0) ? {16{1'($urandom)}} : 16'($urandom);
                queue_sample(u, v, 1'b0, 32'd0);
            end
        end
    endtask

    // Request sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : sender
        tex_item_t it;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.kind       <= it.kind;
                req_ch.texel_col  <= it.col;
                req_ch.texel_row  <= it.row;
                req_ch.texel_rgba <= it.rgba;
                req_ch.coord_u    <= it.u;
                req_ch.coord_v    <= it.v;
                in_flight         <= it;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result receiver: the stall pattern is redrawn whenever the low eight bits of the cycle counter are zero.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count[7:0] == 8'd0)
                stall_mode <= $urandom_range(0, 3);
            unique case (stall_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'($urandom);
                2:       res_ch.ready <= (cycle_count[2:0] != 3'd0);
                default: res_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Each accepted request updates the predictor or predicts a colour.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            if (req_ch.kind == KIND_WRITE)
                model_texels[{req_ch.texel_row, req_ch.texel_col}] = req_ch.texel_rgba;
            else if (in_flight.typed)
                expected_colours.push_back(in_flight.typed_rgba);
            else
                expected_colours.push_back(filter_colour(req_ch.coord_u, req_ch.coord_v));
        end
    end

    // Each result transfer is compared, channel by channel, with the oldest prediction.
    always @(posedge clk)
    begin : colour_check
        logic [31:0] want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            colour_count++;
            if (expected_colours.size() == 0)
            begin
                $display("%0t: unexpected result r=%h g=%h b=%h a=%h", $realtime,
                         res_ch.red, res_ch.green, res_ch.blue, res_ch.alpha);
                fail_count++;
            end
            else
            begin
                want = expected_colours.pop_front();
                if (res_ch.red !== want[7:0])
                begin
                    $display("%0t: red expected %h actual %h", $realtime, want[7:0], res_ch.red);
                    fail_count++;
                end
                if (res_ch.green !== want[15:8])
                begin
                    $display("%0t: green expected %h actual %h", $realtime, want[15:8],
                             res_ch.green);
                    fail_count++;
                end
                if (res_ch.blue !== want[23:16])
                begin
                    $display("%0t: blue expected %h actual %h", $realtime, want[23:16],
                             res_ch.blue);
                    fail_count++;
                end
                if (res_ch.alpha !== want[31:24])
                begin
                    $display("%0t: alpha expected %h actual %h", $realtime, want[31:24],
                             res_ch.alpha);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on any channel ends the run.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] fill;
        tex_item_t   directed[$];
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_TEX_WIDTH;
        cfg_ch.data  = '0;
        req_ch.valid = 1'b0;
        req_ch.kind  = KIND_WRITE;
        req_ch.texel_col  = '0;
        req_ch.texel_row  = '0;
        req_ch.texel_rgba = '0;
        req_ch.coord_u    = '0;
        req_ch.coord_v    = '0;
        res_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset size of 256 by 256.
        fill = 32'hA1B2C3D4;
        directed = '{
            '{KIND_WRITE,  8'd0,   8'd0,   fill,         16'hFFFF, 16'h1234, 0, 0},
            '{KIND_WRITE,  8'd255, 8'd0,   fill,         16'h0000, 16'hFFFF, 0, 0},
            '{KIND_WRITE,  8'd0,   8'd255, fill,         16'h5555, 16'hAAAA, 0, 0},
            '{KIND_WRITE,  8'd255, 8'd255, fill,         16'h0000, 16'h0000, 0, 0},
            '{KIND_SAMPLE, 8'd255, 8'd255, 32'hFFFFFFFF, 16'h0000, 16'h0000, 1, fill},
            '{KIND_SAMPLE, 8'd0,   8'd0,   32'h0,        16'hFFFF, 16'hFFFF, 1, fill},
            '{KIND_SAMPLE, 8'd17,  8'd99,  32'h5A5A5A5A, 16'h0000, 16'hFFFF, 1, fill},
            '{KIND_SAMPLE, 8'd0,   8'd0,   32'h0,        16'hFFFF, 16'h0000, 1, fill},
            '{KIND_WRITE,  8'd0,   8'd0,   32'hFFFFFFFF, 16'h0000, 16'h0000, 0, 0},
            '{KIND_WRITE,  8'd255, 8'd0,   32'h00000000, 16'h0000, 16'h0000, 0, 0},
            '{KIND_WRITE,  8'd0,   8'd255, 32'h00000000, 16'h0000, 16'h0000, 0, 0},
            '{KIND_WRITE,  8'd255, 8'd255, 32'h00000000, 16'h0000, 16'h0000, 0, 0},
            '{KIND_SAMPLE, 8'd0,   8'd0,   32'h0,        16'h0000, 16'h0000, 1, 32'h40404040},
            '{KIND_WRITE,  8'd128, 8'd128, 32'h00FF00FF, 16'hFFFF, 16'hFFFF, 0, 0},
            '{KIND_WRITE,  8'd129, 8'd128, 32'h12345678, 16'h0000, 16'h0000, 0, 0},
            '{KIND_WRITE,  8'd128, 8'd129, 32'h9ABCDEF0, 16'h0000, 16'h0000, 0, 0},
            '{KIND_WRITE,  8'd129, 8'd129, 32'h0F1E2D3C, 16'h0000, 16'h0000, 0, 0},
            '{KIND_SAMPLE, 8'd3,   8'd4,   32'hDEADBEEF, 16'h8080, 16'h8080, 1, 32'h00FF00FF},
            '{KIND_SAMPLE, 8'd0,   8'd0,   32'h0,        16'h80C0, 16'h8080, 0, 0},
            '{KIND_SAMPLE, 8'd0,   8'd0,   32'h0,        16'h80C0, 16'h80C0, 0, 0},
            '{KIND_SAMPLE, 8'd0,   8'd0,   32'h0,        16'h8080, 16'h80C0, 0, 0}
        };
        foreach (directed[i])
        begin
            if (directed[i].kind == KIND_WRITE)
            begin
                planned_texels[{directed[i].row, directed[i].col}] = 1'b1;
                write_count++;
            end
            else
                sample_count++;
            pending_items.push_back(directed[i]);
        end
        wait_until_idle();

        // Random phases: reset size, then extremes, saturation, zero, small and random sizes.
        random_phase(250);
        wait_until_idle();
        write_register(REG_TEX_WIDTH, 9'd1);
        write_register(REG_TEX_HEIGHT, 9'd1);
        random_phase(100);
        wait_until_idle();
        write_register(REG_TEX_WIDTH, 9'd0);
        write_register(REG_TEX_HEIGHT, 9'd0);
        random_phase(80);
        wait_until_idle();
        write_register(REG_TEX_WIDTH, 9'd511);
        write_register(REG_TEX_HEIGHT, 9'd300);
        random_phase(120);
        wait_until_idle();
        write_register(REG_TEX_WIDTH, 9'd3);
        write_register(REG_TEX_HEIGHT, 9'd5);
        random_phase(120);
        wait_until_idle();
        write_register(REG_TEX_WIDTH, 9'd256);
        write_register(REG_TEX_HEIGHT, 9'd1);
        random_phase(120);
        wait_until_idle();
        write_register(REG_TEX_WIDTH, 9'd1);
        write_register(REG_TEX_HEIGHT, 9'd256);
        random_phase(120);
        wait_until_idle();
        write_register(REG_TEX_WIDTH, 9'($urandom_range(2, 256)));
        write_register(REG_TEX_HEIGHT, 9'($urandom_range(2, 16)));
        random_phase(120);
        wait_until_idle();

        $display("Sent %0d texel writes and %0d samples over eight size settings.",
                 write_count, sample_count);
        $display("Checked %0d filtered colours, %0d mismatches.", colour_count, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
